@@ design/onewire_bus_master_macros.svh @@
`ifndef ONEWIRE_BUS_MASTER_MACROS_SVH
`define ONEWIRE_BUS_MASTER_MACROS_SVH

// Same-cycle implication, checked on i_clk, quiet during reset.
`define OW_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on i_clk, quiet during reset.
`define OW_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/ow_pkg.sv @@
`default_nettype none

package ow_pkg;

    localparam int COUNT_WIDTH_DEF = 10;
    localparam int BITS_PER_BYTE   = 8;
    localparam int REG_W           = 10;
    localparam int NUM_REGS        = 8;
    localparam int CFG_ADDR_W      = 3;
    localparam int OP_W            = 2;
    localparam int BYTE_W          = 8;
    localparam int IN_TDATA_W      = 16;
    localparam int OUT_TDATA_W     = 16;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_RST_LOW   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_PRES_WAIT = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_RST_TAIL  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_W1_LOW    = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_SLOT      = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_RD_LOW    = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_RD_SAMPLE = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_RECOVERY  = 3'd7;

    localparam logic [REG_W-1:0] REG_RESET [NUM_REGS] =
        '{10'd500, 10'd100, 10'd400, 10'd5, 10'd60, 10'd5, 10'd5, 10'd1};
    localparam logic [REG_W-1:0] REG_LOW [NUM_REGS] =
        '{10'd1, 10'd1, 10'd0, 10'd1, 10'd2, 10'd1, 10'd0, 10'd0};

    // operation codes
    localparam logic [OP_W-1:0] OP_NONE  = 2'd0;
    localparam logic [OP_W-1:0] OP_RESET = 2'd1;
    localparam logic [OP_W-1:0] OP_WRITE = 2'd2;
    localparam logic [OP_W-1:0] OP_READ  = 2'd3;

endpackage

`default_nettype wire

@@ design/ow_cfg.sv @@
`default_nettype none

// Timing register file; stores each value already clamped to its legal range.
module ow_cfg #(
    parameter int COUNT_WIDTH = ow_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                                            i_clk,
    input  wire logic                                            i_rst_n,
    input  wire logic                                            i_cfg_we,
    input  wire logic [ow_pkg::CFG_ADDR_W-1:0]                   i_cfg_addr,
    input  wire logic [ow_pkg::REG_W-1:0]                        i_cfg_data,
    output logic      [ow_pkg::NUM_REGS-1:0][COUNT_WIDTH-1:0]    o_eff
);
    import ow_pkg::*;

    localparam int EW = (COUNT_WIDTH > REG_W) ? COUNT_WIDTH : REG_W;
    localparam logic [EW-1:0] CMAX = EW'((64'd1 << COUNT_WIDTH) - 64'd1);

    logic [NUM_REGS-1:0][COUNT_WIDTH-1:0] r_eff;

    function automatic logic [COUNT_WIDTH-1:0] clamp(input logic [REG_W-1:0] v,
                                                     input logic [REG_W-1:0] lo);
        logic [EW-1:0] x;
        x = EW'((v < lo) ? lo : v);
        if (x > CMAX) x = CMAX;
        return x[COUNT_WIDTH-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGS; i++) r_eff[i] <= clamp(REG_RESET[i], REG_LOW[i]);
        end else if (i_cfg_we) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                if (i_cfg_addr == CFG_ADDR_W'(i)) r_eff[i] <= clamp(i_cfg_data, REG_LOW[i]);
            end
        end
    end

    assign o_eff = r_eff;

endmodule

`default_nettype wire

@@ design/onewire_bus_master.sv @@
// 1-Wire bus master, one item per microsecond tick.
// Input channel (s_axis): every item is one tick. tuser carries the operation
// (none, reset with presence detect, write byte, read byte); tdata carries the
// byte to write and the sampled bus level. A command is taken only on an idle
// tick and that tick is already its first tick; commands while busy are dropped.
// Output channel (m_axis): exactly one item per input item, in order: drive_low
// for the open-drain pad, busy, done (last tick of a command), the presence
// result of the last reset and the byte of the last read.
// The result is registered: output valid in the cycle after input accept. Throughput:
// one item per cycle while results are taken; the tick update is one registered FSM pass.
// Stall: an output register holds a result until taken; s_axis_tready is high
// whenever that register is empty or is being drained this cycle, so a stalled
// receiver back-pressures the tick stream without losing or repeating items.
// Reset (i_rst_n low, synchronous): FSM idle, counters and bytes zero, timing
// registers back to their defaults, output register empty. Configuration: plain
// write port, one register per write, while idle only: the user's duty, not enforced.
`default_nettype none
`include "onewire_bus_master_macros.svh"

module onewire_bus_master #(
    parameter int COUNT_WIDTH = ow_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // configuration write port
    input  wire logic                              i_cfg_we,
    input  wire logic [ow_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  wire logic [ow_pkg::REG_W-1:0]          i_cfg_data,
    // tick input
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  wire logic [ow_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // data_byte[7:0], line_level[8]
    input  wire logic [ow_pkg::OP_W-1:0]           s_axis_tuser,  // operation[1:0]
    // tick result
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    output logic      [ow_pkg::OUT_TDATA_W-1:0]    m_axis_tdata   // drive_low[0], busy_res[1],
                                                                  // done_res[2], presence[3],
                                                                  // read_data[11:4]
);
    import ow_pkg::*;

    localparam int CW = COUNT_WIDTH;

    // FSM phase codes
    localparam logic [2:0] PH_IDLE       = 3'd0;
    localparam logic [2:0] PH_RST_LOW    = 3'd1;
    localparam logic [2:0] PH_RST_WAIT   = 3'd2;
    localparam logic [2:0] PH_RST_SAMPLE = 3'd3;
    localparam logic [2:0] PH_RST_TAIL   = 3'd4;
    localparam logic [2:0] PH_SLOT       = 3'd5;
    localparam logic [2:0] PH_RECOVER    = 3'd6;

    localparam logic [2:0] LAST_BIT = 3'(BITS_PER_BYTE - 1);

    // effective timing values
    logic [NUM_REGS-1:0][CW-1:0] eff;

    ow_cfg #(.COUNT_WIDTH(CW)) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .o_eff      (eff)
    );

    // FSM state
    logic [2:0]        r_phase, n_phase;
    logic [CW-1:0]     r_tick,  n_tick;
    logic [2:0]        r_bit,   n_bit;
    logic [BYTE_W-1:0] r_shift, n_shift;
    logic              r_pres,  n_pres;
    logic [OP_W-1:0]   r_kind,  n_kind;
    logic [BYTE_W-1:0] r_rdata, n_rdata;

    // output register
    logic                   r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;

    logic in_acc;
    logic drive, busy, done;
    logic [OP_W-1:0]   op;
    logic [BYTE_W-1:0] din;
    logic              line;
    logic [CW:0]       tick_inc;
    logic [CW:0]       samp_pt;
    logic [CW:0]       slot_last;
    logic [CW-1:0]     low_len;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    assign op   = s_axis_tuser;
    assign din  = s_axis_tdata[BYTE_W-1:0];
    assign line = s_axis_tdata[BYTE_W];

    // read sample point, pulled back to the last slot tick when it falls beyond
    assign slot_last = {1'b0, eff[REG_SLOT]} - 1'b1;
    always_comb begin
        samp_pt = {1'b0, eff[REG_RD_LOW]} + {1'b0, eff[REG_RD_SAMPLE]};
        if (samp_pt > slot_last) samp_pt = slot_last;
    end

    always_comb begin
        n_phase = r_phase;
        n_tick  = r_tick;
        n_bit   = r_bit;
        n_shift = r_shift;
        n_pres  = r_pres;
        n_kind  = r_kind;
        n_rdata = r_rdata;
        drive   = 1'b0;
        done    = 1'b0;
        low_len = eff[REG_SLOT];

        // command start on an idle tick
        if (r_phase == PH_IDLE && op != OP_NONE) begin
            n_kind = op;
            n_tick = '0;
            n_bit  = '0;
            if (op == OP_RESET) begin
                n_phase = PH_RST_LOW;
            end else begin
                n_shift = (op == OP_WRITE) ? din : '0;
                n_phase = PH_SLOT;
            end
        end

        busy     = (n_phase != PH_IDLE);
        tick_inc = {1'b0, n_tick} + 1'b1;

        case (n_phase)
            PH_IDLE: begin
            end
            PH_RST_LOW: begin
                drive  = 1'b1;
                n_tick = tick_inc[CW-1:0];
                if (tick_inc >= {1'b0, eff[REG_RST_LOW]}) begin
                    n_phase = PH_RST_WAIT;
                    n_tick  = '0;
                end
            end
            PH_RST_WAIT: begin
                n_tick = tick_inc[CW-1:0];
                if (tick_inc >= {1'b0, eff[REG_PRES_WAIT]}) begin
                    n_phase = PH_RST_SAMPLE;
                    n_tick  = '0;
                end
            end
            PH_RST_SAMPLE: begin
                n_pres = !line;
                n_tick = '0;
                if (eff[REG_RST_TAIL] == '0) begin
                    done    = 1'b1;
                    n_phase = PH_IDLE;
                end else begin
                    n_phase = PH_RST_TAIL;
                end
            end
            PH_RST_TAIL: begin
                n_tick = tick_inc[CW-1:0];
                if (tick_inc >= {1'b0, eff[REG_RST_TAIL]}) begin
                    done    = 1'b1;
                    n_phase = PH_IDLE;
                    n_tick  = '0;
                end
            end
            PH_SLOT: begin
                if (n_kind == OP_WRITE) begin
                    // a one is a short pulse, a zero holds low for the slot
                    low_len = n_shift[0] ? eff[REG_W1_LOW] : eff[REG_SLOT];
                    drive   = (n_tick < low_len);
                end else begin
                    drive = (n_tick < eff[REG_RD_LOW]);
                    if ({1'b0, n_tick} == samp_pt) n_shift = {line, n_shift[BYTE_W-1:1]};
                end
                n_tick = tick_inc[CW-1:0];
                if (tick_inc >= {1'b0, eff[REG_SLOT]}) begin
                    n_tick = '0;
                    if (n_kind == OP_WRITE) n_shift = {1'b0, n_shift[BYTE_W-1:1]};
                    if (n_bit >= LAST_BIT) begin
                        if (n_kind == OP_READ) n_rdata = n_shift;
                        n_bit   = '0;
                        done    = 1'b1;
                        n_phase = PH_IDLE;
                    end else begin
                        n_bit = n_bit + 3'd1;
                        if (eff[REG_RECOVERY] != '0) n_phase = PH_RECOVER;
                    end
                end
            end
            PH_RECOVER: begin
                n_tick = tick_inc[CW-1:0];
                if (tick_inc >= {1'b0, eff[REG_RECOVERY]}) begin
                    n_phase = PH_SLOT;
                    n_tick  = '0;
                end
            end
            default: begin
                n_phase = PH_IDLE;
                n_tick  = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_tick  <= '0;
            r_bit   <= '0;
            r_shift <= '0;
            r_pres  <= 1'b0;
            r_kind  <= OP_NONE;
            r_rdata <= '0;
        end else if (in_acc) begin
            r_phase <= n_phase;
            r_tick  <= n_tick;
            r_bit   <= n_bit;
            r_shift <= n_shift;
            r_pres  <= n_pres;
            r_kind  <= n_kind;
            r_rdata <= n_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_out_data <= {4'd0, n_rdata, n_pres, done, busy, drive};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // done is only ever reported on a busy tick
    `OW_ASSERT_IMPL(a_done_busy, r_out_valid && r_out_data[2], r_out_data[1], "done without busy")
    // the bus is only pulled low by a running command
    `OW_ASSERT_IMPL(a_drive_busy, r_out_valid && r_out_data[0], r_out_data[1], "drive while idle")
    // every way back to idle clears the tick counter
    `OW_ASSERT_IMPL(a_idle_tick, r_phase == PH_IDLE, r_tick == '0, "idle with count")
    // an idle tick with no command produces a non-busy result
    `OW_ASSERT_NEXT(a_idle_none, in_acc && r_phase == PH_IDLE && s_axis_tuser == OP_NONE,
        r_out_valid && !r_out_data[1], "idle tick reported busy")

endmodule

`default_nettype wire

@@ bench/testbench.sv @@
`timescale 1ns / 1ps

import ow_pkg::*;

// Largest value a COUNT_WIDTH-bit tick counter holds.
localparam int BUS_COUNT_MAX = (1 << COUNT_WIDTH_DEF) - 1;

typedef enum logic [2:0] {
    ST_IDLE,
    ST_RST_LOW,
    ST_RST_WAIT,
    ST_RST_SAMPLE,
    ST_RST_TAIL,
    ST_SLOT,
    ST_RECOVER
} t_bus_phase;

// One result item, lowest field last so the packing matches m_axis_tdata[11:0].
typedef struct packed {
    logic [BYTE_W-1:0] read_data;
    logic              presence;
    logic              done;
    logic              busy;
    logic              drive;
} t_bus_state;

// Tracks the bus master's timing state and holds the bus states still to come.
class t_tick_scoreboard;
    logic [REG_W-1:0] timing [NUM_REGS];
    t_bus_phase       phase;
    int               tick_cnt;
    int               bit_idx;
    logic [7:0]       shreg;
    logic             pres_flag;
    logic [OP_W-1:0]  cmd;
    logic [7:0]       last_read;
    t_bus_state       pending_bus_states [$];
    int               errors;
    int               checked;

    function new();
        for (int i = 0; i < NUM_REGS; i++) timing[i] = REG_RESET[i];
        phase     = ST_IDLE;
        tick_cnt  = 0;
        bit_idx   = 0;
        shreg     = '0;
        pres_flag = 1'b0;
        cmd       = OP_NONE;
        last_read = '0;
        errors    = 0;
        checked   = 0;
    endfunction

    function void write_timing(logic [CFG_ADDR_W-1:0] idx, logic [REG_W-1:0] val);
        timing[idx] = val;
    endfunction

    // Register value as the block uses it: raised to its floor, capped at the counter.
    function int eff(logic [CFG_ADDR_W-1:0] idx);
        int v;
        v = int'(timing[idx]);
        if (v < int'(REG_LOW[idx])) v = int'(REG_LOW[idx]);
        if (v > BUS_COUNT_MAX) v = BUS_COUNT_MAX;
        return v;
    endfunction

    function bit is_idle();
        return phase == ST_IDLE;
    endfunction

    function int pending();
        return pending_bus_states.size();
    endfunction

    // Advance one tick and queue the bus state it leaves.
    function void note_tick(logic [OP_W-1:0] op, logic [7:0] data, logic line);
        t_bus_state r;
        int slot;
        int low;
        int rl;
        int sp;
        r = '0;
        if (phase == ST_IDLE && op != OP_NONE) begin
            cmd      = op;
            tick_cnt = 0;
            bit_idx  = 0;
            if (op == OP_RESET) begin
                phase = ST_RST_LOW;
            end else begin
                shreg = (op == OP_WRITE) ? data : 8'h00;
                phase = ST_SLOT;
            end
        end
        if (phase != ST_IDLE) begin
            r.busy = 1'b1;
            case (phase)
                ST_RST_LOW: begin
                    r.drive = 1'b1;
                    tick_cnt++;
                    if (tick_cnt >= eff(REG_RST_LOW)) begin
                        phase    = ST_RST_WAIT;
                        tick_cnt = 0;
                    end
                end
                ST_RST_WAIT: begin
                    tick_cnt++;
                    if (tick_cnt >= eff(REG_PRES_WAIT)) begin
                        phase    = ST_RST_SAMPLE;
                        tick_cnt = 0;
                    end
                end
                ST_RST_SAMPLE: begin
                    pres_flag = !line;
                    tick_cnt  = 0;
                    if (eff(REG_RST_TAIL) == 0) begin
                        r.done = 1'b1;
                        phase  = ST_IDLE;
                    end else begin
                        phase = ST_RST_TAIL;
                    end
                end
                ST_RST_TAIL: begin
                    tick_cnt++;
                    if (tick_cnt >= eff(REG_RST_TAIL)) begin
                        r.done   = 1'b1;
                        phase    = ST_IDLE;
                        tick_cnt = 0;
                    end
                end
                ST_SLOT: begin
                    slot = eff(REG_SLOT);
                    if (cmd == OP_WRITE) begin
                        low     = shreg[0] ? eff(REG_W1_LOW) : slot;
                        r.drive = (tick_cnt < low);
                    end else begin
                        rl = eff(REG_RD_LOW);
                        sp = rl + eff(REG_RD_SAMPLE);
                        if (sp > slot - 1) sp = slot - 1;
                        r.drive = (tick_cnt < rl);
                        if (tick_cnt == sp) shreg = {line, shreg[7:1]};
                    end
                    tick_cnt++;
                    if (tick_cnt >= slot) begin
                        tick_cnt = 0;
                        if (cmd == OP_WRITE) shreg = shreg >> 1;
                        if (bit_idx >= BITS_PER_BYTE - 1) begin
                            if (cmd == OP_READ) last_read = shreg;
                            bit_idx = 0;
                            r.done  = 1'b1;
                            phase   = ST_IDLE;
                        end else begin
                            bit_idx = (bit_idx + 1) & 7;
                            if (eff(REG_RECOVERY) != 0) phase = ST_RECOVER;
                        end
                    end
                end
                ST_RECOVER: begin
                    tick_cnt++;
                    if (tick_cnt >= eff(REG_RECOVERY)) begin
                        phase    = ST_SLOT;
                        tick_cnt = 0;
                    end
                end
                default: begin
                    phase    = ST_IDLE;
                    tick_cnt = 0;
                end
            endcase
            tick_cnt &= BUS_COUNT_MAX;
        end
        r.presence = pres_flag;
        r.read_data = last_read;
        pending_bus_states.push_back(r);
    endfunction

    task report(string field, int exp_v, int got_v);
        $display("mismatch at result %0d: %s expected %0h got %0h",
                 checked, field, exp_v, got_v);
        errors++;
    endtask

    task check_result(logic [OUT_TDATA_W-1:0] word);
        t_bus_state e;
        t_bus_state g;
        g = word[$bits(t_bus_state)-1:0];
        if (pending_bus_states.size() == 0) begin
            report("unexpected item", 0, int'(word));
        end else begin
            e = pending_bus_states.pop_front();
            if (g.drive !== e.drive) report("drive_low", e.drive, g.drive);
            if (g.busy !== e.busy) report("busy", e.busy, g.busy);
            if (g.done !== e.done) report("done", e.done, g.done);
            if (g.presence !== e.presence) report("presence", e.presence, g.presence);
            if (g.read_data !== e.read_data) report("read_data", e.read_data, g.read_data);
        end
        checked++;
    endtask
endclass

module testbench;

    // Watchdog limit, kept well above the slowest run.
    localparam int CYCLE_LIMIT = 100_000;
    // Results taken before the receiver's one long hold-off, and its length.
    localparam int HOLD_AFTER  = 200;
    localparam int HOLD_CYCLES = 400;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [CFG_ADDR_W-1:0]  i_cfg_addr;
    logic [REG_W-1:0]       i_cfg_data;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;   // data_byte[7:0], line_level[8]
    logic [OP_W-1:0]        s_axis_tuser;   // operation[1:0]
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;   // drive_low[0], busy[1], done[2],
                                            // presence[3], read_data[11:4]

    t_tick_scoreboard sb;
    bit               no_gaps;     // when set, neither side idles
    int               rx_count;
    int               cycles;

    always #5 i_clk = ~i_clk;

    onewire_bus_master dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Watchdog: a hung handshake ends the run here.
    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("status: fail");
        $finish;
    end

    // Offer one tick item; entered and left at a falling edge.
    task automatic send_tick(input logic [OP_W-1:0] op, input logic [7:0] data,
                             input logic line);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 13);
        if (gap != 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = op;
        s_axis_tdata  = {{(IN_TDATA_W-BYTE_W-1){1'b0}}, line, data};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_tick(op, data, line);
        @(negedge i_clk);
    endtask

    // Start a command, then tick it to completion. Now and then a command
    // lands mid-run; the block must drop it.
    task automatic run_command(input logic [OP_W-1:0] op, input logic [7:0] data);
        logic [OP_W-1:0] noise;
        send_tick(op, data, 1'($urandom));
        while (!sb.is_idle()) begin
            noise = ($urandom_range(0, 7) == 0) ? OP_W'($urandom) : OP_NONE;
            send_tick(noise, 8'($urandom), 1'($urandom));
        end
    endtask

    // Registers change only with nothing in flight.
    task automatic set_reg(input logic [CFG_ADDR_W-1:0] idx, input int val);
        s_axis_tvalid = 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_addr = idx;
        i_cfg_data = REG_W'(val);
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
        sb.write_timing(idx, REG_W'(val));
    endtask

    task automatic load_timing(input int rst_low, input int pres_wait, input int rst_tail,
                               input int w1_low, input int slot, input int rd_low,
                               input int rd_sample, input int recovery);
        set_reg(REG_RST_LOW, rst_low);
        set_reg(REG_PRES_WAIT, pres_wait);
        set_reg(REG_RST_TAIL, rst_tail);
        set_reg(REG_W1_LOW, w1_low);
        set_reg(REG_SLOT, slot);
        set_reg(REG_RD_LOW, rd_low);
        set_reg(REG_RD_SAMPLE, rd_sample);
        set_reg(REG_RECOVERY, recovery);
    endtask

    // Result side: random stalls per item, plus one long hold-off so the
    // output register fills and the tick stream backs up.
    initial begin
        int  stall;
        bit  held;
        m_axis_tready = 1'b0;
        rx_count      = 0;
        held          = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if (!held && rx_count >= HOLD_AFTER) begin
                m_axis_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                held = 1'b1;
            end
            stall = no_gaps ? 0 : $urandom_range(0, 13);
            if (stall != 0) begin
                m_axis_tready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            m_axis_tready = 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
            sb.check_result(m_axis_tdata);
            rx_count++;
            @(negedge i_clk);
        end
    end

    initial begin
        logic [OP_W-1:0] op;
        sb            = new();
        no_gaps       = 1'b0;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_addr    = '0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_NONE;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // --- directed: pulse, sample and recovery defaults in short slots ---
        send_tick(OP_NONE, 8'h00, 1'b0);   // idle ticks: bus released, not busy
        send_tick(OP_NONE, 8'hFF, 1'b1);
        set_reg(REG_RST_LOW, 2);
        set_reg(REG_PRES_WAIT, 1);
        set_reg(REG_RST_TAIL, 2);
        set_reg(REG_SLOT, 6);
        run_command(OP_RESET, 8'h00);
        run_command(OP_WRITE, 8'hA5);
        run_command(OP_READ, 8'h00);

        // every register written as zero, at or below its floor; slot 0, then slot 1
        load_timing(0, 0, 0, 0, 0, 0, 0, 0);
        run_command(OP_WRITE, 8'hA5);
        run_command(OP_READ, 8'h00);
        run_command(OP_RESET, 8'h00);
        set_reg(REG_SLOT, 1);
        run_command(OP_WRITE, 8'h3C);

        // low pulses longer than the slot, no tail, no recovery
        load_timing(3, 2, 0, 9, 3, 7, 3, 0);
        run_command(OP_WRITE, 8'h5A);
        run_command(OP_READ, 8'h00);
        run_command(OP_RESET, 8'h00);

        // read sample point past the end of the slot
        load_timing(2, 3, 1, 1, 4, 2, 9, 1);
        run_command(OP_READ, 8'h00);

        // --- random: short timings, random commands, bytes and line levels ---
        for (int n = 0; n < 8; n++) begin
            if (n == 0 || $urandom_range(0, 2) == 0) begin
                load_timing($urandom_range(0, 4), $urandom_range(0, 3),
                            $urandom_range(0, 3), $urandom_range(0, 3),
                            $urandom_range(0, 4), $urandom_range(0, 3),
                            $urandom_range(0, 4), $urandom_range(0, 2));
                if ($urandom_range(0, 4) == 0)
                    set_reg(CFG_ADDR_W'($urandom), $urandom_range(0, 4));
            end
            if ($urandom_range(0, 3) == 0) no_gaps = !no_gaps;
            repeat ($urandom_range(0, 3)) send_tick(OP_NONE, 8'($urandom), 1'($urandom));
            op = OP_W'($urandom_range(1, 3));
            run_command(op, 8'($urandom));
        end

        // drain, then give stray results a chance to show up
        s_axis_tvalid = 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
